// ===== sv/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: widths, phase codes, register map, shared structs.
package uer_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam int TRIG_W  = 8;
    localparam int SCALE_W = 12;
    localparam int GAP_W   = 24;
    localparam int DIST_W  = 12;
    localparam int HUND_W  = 6;
    localparam int DIGIT_W = 4;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam int PROD_W         = COUNT_WIDTH + SCALE_W;
    localparam int DIST_FRAC_BITS = 16;
    localparam int DIST_Q_W       = 24;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [DIST_W-1:0]      DIST_MAX  = 12'd4095;
    localparam logic [GAP_W-1:0]       TRIG_LOW_TICKS = 24'd2;

    localparam logic [TRIG_W-1:0]  TRIG_HIGH_RESET = 8'd15;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 12'd1226;
    localparam logic [GAP_W-1:0]   GAP_RESET       = 24'd184332;

    // Constant division by reciprocal multiply, exact over the used ranges.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV10_MUL    = 205;
    localparam int DIV10_SHIFT  = 11;

    typedef enum logic [1:0] {
        REG_TRIG_HIGH = 2'd0,
        REG_SCALE     = 2'd1,
        REG_GAP       = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_TRIG_LOW  = 3'd0,
        PH_TRIG_HIGH = 3'd1,
        PH_WAIT_ECHO = 3'd2,
        PH_COUNT     = 3'd3,
        PH_GAP       = 3'd4
    } t_phase;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_high_ticks;
        logic [SCALE_W-1:0] scale_q16;
        logic [GAP_W-1:0]   gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic              trigger;
        logic              done_res;
        logic [DIST_W-1:0] distance_cm;
        logic              overflow;
    } t_meas;

endpackage

// ===== sv/uer_in_if.sv =====
// Input channel: one timer tick with the sampled echo level.
interface uer_in_if;
    logic valid;
    logic ready;
    logic echo;

    modport source (output valid, output echo, input ready);
    modport sink   (input valid, input echo, output ready);
endinterface

// ===== sv/uer_out_if.sv =====
// Result channel: trigger level, completion flag, distance and its decimal digits.
interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger;
    logic        done_res;
    logic [11:0] distance_cm;
    logic [5:0]  hundreds;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic        overflow;

    modport source (output valid, output trigger, output done_res, output distance_cm,
                    output hundreds, output tens, output ones, output overflow,
                    input ready);
    modport sink   (input valid, input trigger, input done_res, input distance_cm,
                    input hundreds, input tens, input ones, input overflow,
                    output ready);
endinterface

// ===== sv/uer_cfg.sv =====
// APB-style configuration registers for the echo ranger.
module uer_cfg import uer_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [TRIG_W-1:0]  r_trig_high;
    logic [SCALE_W-1:0] r_scale;
    logic [GAP_W-1:0]   r_gap;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_high <= TRIG_HIGH_RESET;
            r_scale     <= SCALE_RESET;
            r_gap       <= GAP_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_TRIG_HIGH: r_trig_high <= pwdata[TRIG_W-1:0];
                REG_SCALE:     r_scale     <= pwdata[SCALE_W-1:0];
                REG_GAP:       r_gap       <= pwdata[GAP_W-1:0];
                default: begin
                    // drop writes beyond the register map
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TRIG_HIGH: prdata = DATA_W'(r_trig_high);
            REG_SCALE:     prdata = DATA_W'(r_scale);
            REG_GAP:       prdata = DATA_W'(r_gap);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.trigger_high_ticks = r_trig_high;
    assign o_cfg.scale_q16          = r_scale;
    assign o_cfg.gap_ticks          = r_gap;

endmodule

// ===== sv/uer_ctrl.sv =====
// Phase sequencer and echo timer: input register, per-tick state update, measurement register.
module uer_ctrl import uer_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    uer_in_if.sink i_echo_ch,
    output logic  o_meas_valid,
    input  logic  i_meas_ready,
    output t_meas o_meas
);

    logic                   r_in_valid;
    logic                   r_in_echo;
    logic                   r_m_valid;
    t_meas                  r_meas;
    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [GAP_W-1:0]       r_ticks;
    logic [GAP_W-1:0]       n_ticks;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_sat;
    logic                   n_sat;

    logic                   w_fire;
    logic [GAP_W-1:0]       w_ticks_inc;
    logic [PROD_W-1:0]      w_prod;
    logic [DIST_Q_W-1:0]    w_q;
    t_meas                  w_meas;

    assign w_fire          = r_in_valid && (!r_m_valid || i_meas_ready);
    assign i_echo_ch.ready = !r_in_valid || w_fire;
    assign w_ticks_inc     = r_ticks + GAP_W'(1);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_count = r_count;
        n_sat   = r_sat;
        case (r_phase)
            PH_TRIG_HIGH: begin
                if (w_ticks_inc >= GAP_W'(i_cfg.trigger_high_ticks)) begin
                    n_phase = PH_WAIT_ECHO;
                    n_ticks = '0;
                end else begin
                    n_ticks = w_ticks_inc;
                end
            end
            PH_WAIT_ECHO: begin
                if (r_in_echo) begin
                    n_phase = PH_COUNT;
                    n_count = COUNT_WIDTH'(1);
                    n_sat   = 1'b0;
                end
            end
            PH_COUNT: begin
                if (r_in_echo) begin
                    if (r_count == COUNT_MAX) begin
                        n_sat = 1'b1;
                    end else begin
                        n_count = r_count + COUNT_WIDTH'(1);
                    end
                end else begin
                    n_ticks = '0;
                    n_phase = (i_cfg.gap_ticks == '0) ? PH_TRIG_LOW : PH_GAP;
                end
            end
            PH_GAP: begin
                if (w_ticks_inc >= i_cfg.gap_ticks) begin
                    n_phase = PH_TRIG_LOW;
                    n_ticks = '0;
                end else begin
                    n_ticks = w_ticks_inc;
                end
            end
            default: begin
                if (w_ticks_inc >= TRIG_LOW_TICKS) begin
                    n_phase = PH_TRIG_HIGH;
                    n_ticks = '0;
                end else begin
                    n_phase = PH_TRIG_LOW;
                    n_ticks = w_ticks_inc;
                end
            end
        endcase
    end

    // Outputs of this tick
    assign w_prod = PROD_W'(r_count) * PROD_W'(i_cfg.scale_q16);
    assign w_q    = DIST_Q_W'(w_prod >> DIST_FRAC_BITS);

    always_comb begin
        w_meas = '0;
        case (r_phase)
            PH_TRIG_HIGH: begin
                w_meas.trigger = 1'b1;
            end
            PH_COUNT: begin
                if (!r_in_echo) begin
                    w_meas.done_res    = 1'b1;
                    w_meas.distance_cm = (w_q > DIST_Q_W'(DIST_MAX)) ? DIST_MAX
                                                                     : w_q[DIST_W-1:0];
                    w_meas.overflow    = r_sat;
                end
            end
            default: begin
                w_meas = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_phase    <= PH_TRIG_LOW;
            r_ticks    <= '0;
            r_count    <= '0;
            r_sat      <= 1'b0;
        end else begin
            if (i_echo_ch.valid && i_echo_ch.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_m_valid <= 1'b1;
                r_phase   <= n_phase;
                r_ticks   <= n_ticks;
                r_count   <= n_count;
                r_sat     <= n_sat;
            end else if (i_meas_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_echo_ch.valid && i_echo_ch.ready) begin
            r_in_echo <= i_echo_ch.echo;
        end
        if (w_fire) begin
            r_meas <= w_meas;
        end
    end

    assign o_meas_valid = r_m_valid;
    assign o_meas       = r_meas;

endmodule

// ===== sv/uer_digits.sv =====
// Decimal split of the distance and the result register that drives the output channel.
module uer_digits import uer_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_meas_valid,
    output logic  o_meas_ready,
    input  t_meas i_meas,
    uer_out_if.source o_res_ch
);

    localparam int H_PROD_W = DIST_W + 13;
    localparam int REM_W    = 7;
    localparam int T_PROD_W = REM_W + 8;

    logic                r_valid;
    logic                r_trigger;
    logic                r_done;
    logic [DIST_W-1:0]   r_dist;
    logic [HUND_W-1:0]   r_hund;
    logic [DIGIT_W-1:0]  r_tens;
    logic [DIGIT_W-1:0]  r_ones;
    logic                r_ovf;

    logic [H_PROD_W-1:0] w_h_prod;
    logic [HUND_W-1:0]   w_hund;
    logic [DIST_W-1:0]   w_h100;
    logic [REM_W-1:0]    w_rem;
    logic [T_PROD_W-1:0] w_t_prod;
    logic [DIGIT_W-1:0]  w_tens;
    logic [DIGIT_W-1:0]  w_ones;
    logic                w_load;

    // hundreds = d / 100, then tens and ones from the remainder below 100
    assign w_h_prod = H_PROD_W'(i_meas.distance_cm) * H_PROD_W'(DIV100_MUL);
    assign w_hund   = HUND_W'(w_h_prod >> DIV100_SHIFT);
    assign w_h100   = DIST_W'(w_hund) * DIST_W'(100);
    assign w_rem    = REM_W'(i_meas.distance_cm - w_h100);
    assign w_t_prod = T_PROD_W'(w_rem) * T_PROD_W'(DIV10_MUL);
    assign w_tens   = DIGIT_W'(w_t_prod >> DIV10_SHIFT);
    assign w_ones   = DIGIT_W'(w_rem - (REM_W'(w_tens) * REM_W'(10)));

    assign o_meas_ready = !r_valid || o_res_ch.ready;
    assign w_load       = i_meas_valid && o_meas_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_trigger <= i_meas.trigger;
            r_done    <= i_meas.done_res;
            r_dist    <= i_meas.distance_cm;
            r_hund    <= w_hund;
            r_tens    <= w_tens;
            r_ones    <= w_ones;
            r_ovf     <= i_meas.overflow;
        end
    end

    assign o_res_ch.valid       = r_valid;
    assign o_res_ch.trigger     = r_trigger;
    assign o_res_ch.done_res    = r_done;
    assign o_res_ch.distance_cm = r_dist;
    assign o_res_ch.hundreds    = r_hund;
    assign o_res_ch.tens        = r_tens;
    assign o_res_ch.ones        = r_ones;
    assign o_res_ch.overflow    = r_ovf;

endmodule

// ===== sv/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config registers, sequencer, digit stage.
//
// Usage:
//   i_echo_ch carries one item per timer tick with the sampled echo level.
//   o_res_ch returns exactly one item per input item, in order: the trigger
//   level for that tick, done_res on the tick the echo falls, and on that
//   tick the distance in centimetres with hundreds, tens and ones digits and
//   the counter overflow flag (all zero on other ticks).
//   The APB-style port writes trigger_high_ticks (0x0), scale_q16 (0x4) and
//   gap_ticks (0x8); write only while no item is in flight.
// Timing:
//   Three register stages (input, sequencer, digit split). A result item is
//   offered from the digit register after the input and sequencer; one item
//   is taken and one delivered each cycle while the receiver keeps ready high.
// Reset:
//   Synchronous, active low. Empties the pipe, loads the register defaults
//   and restarts the sequence in the trigger-low phase with counts at zero.
// Stall:
//   A low ready on o_res_ch holds the result register; stages behind it keep
//   filling, and i_echo_ch.ready drops only once every stage holds an item.
module ultrasonic_echo_ranger import uer_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uer_in_if.sink            i_echo_ch,
    uer_out_if.source         o_res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg  w_cfg;
    t_meas w_meas;
    logic  w_meas_valid;
    logic  w_meas_ready;

    // Configuration registers, taken as written with no shadowing
    uer_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance the phase sequence one tick per item and time the echo pulse
    uer_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_echo_ch    (i_echo_ch),
        .o_meas_valid (w_meas_valid),
        .i_meas_ready (w_meas_ready),
        .o_meas       (w_meas)
    );

    // Split the distance into decimal digits and hold the result item
    uer_digits u_digits (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_meas_valid (w_meas_valid),
        .o_meas_ready (w_meas_ready),
        .i_meas       (w_meas),
        .o_res_ch     (o_res_ch)
    );

endmodule
